/* hw/rtl/esb_pkg.sv */
`default_nettype none

package esb_pkg;

  // Element width and default buffer depth
  localparam int ESB_DATA_W       = 32;
  localparam int ESB_MAX_ELEMENTS = 16;

  // Register map: byte address bit 2 selects the register word
  localparam int ESB_PADDR_W = 3;
  localparam logic ESB_REG_DESCENDING = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_HOLD,
    S_SCAN,
    S_WB_I,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } esb_state_t;

endpackage

`default_nettype wire

/* hw/rtl/esb_store.sv */
`default_nettype none

module esb_store
  import esb_pkg::*;
#(
  parameter int MAX_ELEMENTS = ESB_MAX_ELEMENTS,
  localparam int AW = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic signed [ESB_DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]                rd_addr,
  output logic signed [ESB_DATA_W-1:0]      rd_data
);

  logic signed [ESB_DATA_W-1:0] mem [MAX_ELEMENTS];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/esb_ctrl.sv */
`default_nettype none

module esb_ctrl
  import esb_pkg::*;
#(
  parameter int MAX_ELEMENTS = ESB_MAX_ELEMENTS,
  localparam int AW = $clog2(MAX_ELEMENTS),
  localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         descending,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [ESB_DATA_W-1:0] value,
  input  wire logic                         is_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ESB_DATA_W-1:0]      sorted_value,
  output logic                              end_of_set,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic signed [ESB_DATA_W-1:0]      wr_data,
  output logic [AW-1:0]                     rd_addr,
  input  wire logic signed [ESB_DATA_W-1:0] rd_data
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ELEMENTS);

  esb_state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  logic signed [ESB_DATA_W-1:0] held;

  logic          in_take;
  logic          has_room;
  logic [CW-1:0] n_next;
  logic [AW-1:0] last_idx;
  logic          swap;
  logic          out_take;

  // Common terms
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign has_room = (count < FULL_COUNT);
  assign n_next   = has_room ? (count + 1'b1) : count;
  assign last_idx = AW'(n - 1'b1);
  assign swap     = descending ? (held < rd_data) : (held > rd_data);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_take && is_last) begin
          state_next = (n_next < CW'(2)) ? S_EMIT_RD : S_RD_I;
        end
      end
      S_RD_I:    state_next = S_HOLD;
      S_HOLD:    state_next = S_SCAN;
      S_SCAN: begin
        if (j == last_idx) begin
          state_next = S_WB_I;
        end
      end
      S_WB_I: begin
        state_next = (AW'(i + 1'b1) == last_idx) ? S_EMIT_RD : S_RD_I;
      end
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: begin
        if (out_take) begin
          state_next = end_of_set ? S_LOAD : S_EMIT_RD;
        end
      end
      default:   state_next = S_LOAD;
    endcase
  end

  // Memory access and handshake outputs
  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    wr_addr  = i;
    wr_data  = held;
    rd_addr  = k;
    unique case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        wr_en    = in_valid && has_room;
        wr_addr  = count[AW-1:0];
        wr_data  = value;
      end
      S_RD_I:  rd_addr = i;
      S_HOLD:  rd_addr = AW'(i + 1'b1);
      S_SCAN: begin
        wr_en   = swap;
        wr_addr = j;
        wr_data = held;
        rd_addr = AW'(j + 1'b1);
      end
      S_WB_I: begin
        wr_en   = 1'b1;
        wr_addr = i;
        wr_data = held;
      end
      S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT: rd_addr = k;
      default: rd_addr = k;
    endcase
  end

  // State and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD && in_take) begin
        count <= n_next;
      end
      if (state == S_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
        if (end_of_set) begin
          count <= '0;
        end
      end
    end
  end

  // Sort indexes, held element and output payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (in_take && is_last) begin
          n <= n_next;
          i <= '0;
          k <= '0;
        end
      end
      S_HOLD: begin
        held <= rd_data;
        j    <= AW'(i + 1'b1);
      end
      S_SCAN: begin
        if (swap) begin
          held <= rd_data;
        end
        j <= AW'(j + 1'b1);
      end
      S_WB_I: i <= AW'(i + 1'b1);
      S_EMIT_LD: begin
        sorted_value <= rd_data;
        end_of_set   <= (k == last_idx);
      end
      S_EMIT_WAIT: begin
        if (out_take) begin
          k <= AW'(k + 1'b1);
        end
      end
      S_RD_I, S_EMIT_RD: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/exchange_sort_buffer.sv */
// Channel | Direction | Handshake           | Payload
// in      | in        | in_valid / in_stall   | value, is_last
// out     | out       | out_valid / out_stall | sorted_value, end_of_set
// cfg     | in        | APB psel/penable      | descending at byte address 0
//
// Load accepts one request per cycle until one marked last.
// Sorting runs one pass per index i = 0..n-2; each pass walks the element
// memory (one write port, one read port) with one compare per cycle.
// Each result then passes the memory read, load and handshake states and waits out any out_stall.
// Reset is synchronous; the element memory needs no clearing pass.
// No request is accepted from the last load until the final result is taken.
`default_nettype none

module exchange_sort_buffer
  import esb_pkg::*;
#(
  parameter int MAX_ELEMENTS = ESB_MAX_ELEMENTS,
  localparam int AW = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ESB_PADDR_W-1:0]       paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [ESB_DATA_W-1:0] value,
  input  wire logic                         is_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ESB_DATA_W-1:0]      sorted_value,
  output logic                              end_of_set
);

  logic                         descending;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [ESB_DATA_W-1:0] wr_data;
  logic [AW-1:0]                rd_addr;
  logic signed [ESB_DATA_W-1:0] rd_data;
  logic                         reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ESB_REG_DESCENDING);
  assign prdata  = reg_sel ? {31'b0, descending} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      descending <= pwdata[0];
    end
  end

  esb_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .descending   (descending),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  esb_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/esb_checker.sv */
`default_nettype none

module esb_checker
  import esb_pkg::*;
(
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         is_last,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic signed [ESB_DATA_W-1:0] sorted_value,
  input wire logic                         end_of_set
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(end_of_set))
    else $error("stalled result changed");

  // Drop out of load after the last element
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> in_stall)
    else $error("input taken right after last element");

  // Leave a gap after each taken result
  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result valid right after a taken result");

  // Clear the output after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind exchange_sort_buffer esb_checker u_esb_checker (.*);

`default_nettype wire
